// ===== rtl/core/lrupf_pkg.sv =====
package lrupf_pkg;

  // Fixed field widths of the item channels and the config register.
  localparam int unsigned PAGE_FIELD_W  = 16;
  localparam int unsigned FRAME_FIELD_W = 4;
  localparam int unsigned FAULT_W       = 16;
  localparam int unsigned CFG_W         = 5;

  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX           = 16'hFFFF;

  // Command codes
  localparam logic CMD_REFERENCE = 1'b0;
  localparam logic CMD_CLEAR     = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [PAGE_FIELD_W-1:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [FRAME_FIELD_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_FIELD_W-1:0]  evicted_page;
    logic [FAULT_W-1:0]       fault_total;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input item
    logic search;  // register lookup and victim choice
    logic commit;  // update frames and load the result register
  } dp_cmd_t;

endpackage

// ===== rtl/core/lru_page_frame_replacement.sv =====
// LRU page frame store.
// Input channel (in_valid_i / in_stall_o, in_item_i): one item per page
// reference or clear command. Output channel (out_valid_o / out_stall_i,
// out_item_o): exactly one result item per input item, in order.
// Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i): frames_in_use,
// always ready; write it only while the block is idle. 0 acts as 1,
// values above FRAMES act as FRAMES.
// An accepted item passes a search state and then an update state. The
// search state runs the parallel tag compare over all frames and the
// oldest-rank tree; the update state ages ranks, writes the frame and loads
// the result register, and a new item can be accepted as it does so.
// A new item is taken while a finished result still waits; its update
// holds until the result register is free, so a stalled receiver backs
// up into in_stall_o after one more item.
// Reset: all frames empty, ranks and fault count zero, frames_in_use 16.
// No clearing pass; page tags are only read behind their valid bits.
module lru_page_frame_replacement #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lrupf_pkg::in_item_t         in_item_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lrupf_pkg::out_item_t        out_item_o,
  // config write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lrupf_pkg::CFG_W-1:0] cfg_data_i
);
  import lrupf_pkg::*;

  dp_cmd_t cmd;

  // Config register is a plain flop, never busy.
  assign cfg_ready_o = 1'b1;

  lrupf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lrupf_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== rtl/core/lrupf_ctrl.sv =====
module lrupf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lrupf_pkg::dp_cmd_t cmd_o
);
  import lrupf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_commit, commit, accept;

  // Result register is free when empty or being taken this cycle.
  assign can_commit = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_UPDATE) && can_commit;
  assign in_stall_o = !((state_q == ST_IDLE) || commit);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (commit) state_d = accept ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.load   = accept;
  assign cmd_o.search = (state_q == ST_SEARCH);
  assign cmd_o.commit = commit;

endmodule

// ===== rtl/core/lrupf_victim.sv =====
module lrupf_victim #(
  parameter int unsigned FRAMES = 16,
  parameter int unsigned IDX_W  = $clog2(FRAMES),
  parameter int unsigned RANK_W = $clog2(FRAMES)
) (
  input  logic [FRAMES-1:0] cand_i,
  input  logic [RANK_W-1:0] rank_i [FRAMES],
  output logic [IDX_W-1:0]  idx_o
);
  // Max-rank tree, ties go to the lower index (left branch).
  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  logic              node_ok   [NODES];
  logic [RANK_W-1:0] node_rank [NODES];
  logic [IDX_W-1:0]  node_idx  [NODES];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < FRAMES) begin : g_real
      assign node_ok[LEAVES-1+i]   = cand_i[i];
      assign node_rank[LEAVES-1+i] = rank_i[i];
    end else begin : g_pad
      assign node_ok[LEAVES-1+i]   = 1'b0;
      assign node_rank[LEAVES-1+i] = '0;
    end
    assign node_idx[LEAVES-1+i] = IDX_W'(i);
  end

  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    logic take_left;
    assign take_left = node_ok[2*k+1] &&
                       (!node_ok[2*k+2] || (node_rank[2*k+1] >= node_rank[2*k+2]));
    assign node_ok[k]   = node_ok[2*k+1] || node_ok[2*k+2];
    assign node_rank[k] = take_left ? node_rank[2*k+1] : node_rank[2*k+2];
    assign node_idx[k]  = take_left ? node_idx[2*k+1]  : node_idx[2*k+2];
  end

  // No candidate: frame zero.
  assign idx_o = node_ok[0] ? node_idx[0] : '0;

endmodule

// ===== rtl/core/lrupf_datapath.sv =====
module lrupf_datapath #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lrupf_pkg::dp_cmd_t          cmd_i,
  input  lrupf_pkg::in_item_t         in_item_i,
  input  logic                        cfg_we_i,
  input  logic [lrupf_pkg::CFG_W-1:0] cfg_data_i,
  output lrupf_pkg::out_item_t        out_item_o
);
  import lrupf_pkg::*;

  localparam int unsigned IDX_W  = $clog2(FRAMES);
  localparam int unsigned RANK_W = $clog2(FRAMES);
  localparam int unsigned NW     = $clog2(FRAMES + 1);
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

  // Frame store
  logic [PAGE_BITS-1:0] page_q  [FRAMES];
  logic [FRAMES-1:0]    valid_q;
  logic [RANK_W-1:0]    rank_q  [FRAMES];
  logic [FAULT_W-1:0]   fault_q;
  logic [CFG_W-1:0]     frames_in_use_q;

  // Item and search results
  logic                 item_clear_q;
  logic [PAGE_BITS-1:0] item_page_q;
  logic                 hit_q;
  logic                 evict_q;
  logic [IDX_W-1:0]     slot_q;
  out_item_t            out_q;

  // Active frame count, clamped to 1..FRAMES
  logic [31:0]       cfg_wide;
  logic [NW-1:0]     n_act;
  logic [FRAMES-1:0] active;

  assign cfg_wide = 32'(frames_in_use_q);
  always_comb begin
    if (cfg_wide == 32'd0) n_act = NW'(1);
    else if (cfg_wide > 32'(FRAMES)) n_act = NW'(FRAMES);
    else n_act = NW'(cfg_wide);
  end

  for (genvar i = 0; i < FRAMES; i++) begin : g_active
    assign active[i] = (NW'(i) < n_act);
  end

  // Lookup
  logic [47:0]          page_ext;
  logic [PAGE_BITS-1:0] ref_page;
  logic [FRAMES-1:0]    match, free;
  logic                 hit_any, free_any;
  logic [IDX_W-1:0]     hit_idx, free_idx, vic_idx;

  assign page_ext = 48'(in_item_i.page_number);
  assign ref_page = page_ext[PAGE_BITS-1:0];

  for (genvar i = 0; i < FRAMES; i++) begin : g_cmp
    assign match[i] = active[i] && valid_q[i] && (page_q[i] == item_page_q);
    assign free[i]  = active[i] && !valid_q[i];
  end

  // Lowest index wins.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (free[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  lrupf_victim #(
    .FRAMES (FRAMES),
    .IDX_W  (IDX_W),
    .RANK_W (RANK_W)
  ) u_victim (
    .cand_i (active),
    .rank_i (rank_q),
    .idx_o  (vic_idx)
  );

  // Update
  logic [RANK_W-1:0]  slot_rank;
  logic [FRAMES-1:0]  age;
  logic [FAULT_W-1:0] fault_next;
  logic [47:0]        ev_ext;
  logic [31:0]        slot_ext;

  assign slot_rank = rank_q[slot_q];
  assign ev_ext    = 48'(page_q[slot_q]);
  assign slot_ext  = 32'(slot_q);

  for (genvar i = 0; i < FRAMES; i++) begin : g_age
    assign age[i] = active[i] && valid_q[i] && (IDX_W'(i) != slot_q) &&
                    (hit_q ? (rank_q[i] < slot_rank) : (rank_q[i] != RANK_MAX));
  end

  always_comb begin
    fault_next = fault_q;
    if (!hit_q && (fault_q != FAULT_MAX)) fault_next = fault_q + FAULT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q         <= '0;
      fault_q         <= '0;
      frames_in_use_q <= FRAMES_IN_USE_RESET;
      for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
    end else begin
      if (cfg_we_i) frames_in_use_q <= cfg_data_i;
      if (cmd_i.commit) begin
        if (item_clear_q) begin
          valid_q <= '0;
          fault_q <= '0;
          for (int i = 0; i < FRAMES; i++) rank_q[i] <= '0;
        end else begin
          fault_q         <= fault_next;
          valid_q[slot_q] <= 1'b1;
          for (int i = 0; i < FRAMES; i++) begin
            if (age[i]) rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
          rank_q[slot_q] <= '0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_clear_q <= (in_item_i.command == CMD_CLEAR);
      item_page_q  <= ref_page;
    end
    if (cmd_i.search) begin
      hit_q   <= hit_any;
      evict_q <= !hit_any && !free_any;
      slot_q  <= hit_any ? hit_idx : (free_any ? free_idx : vic_idx);
    end
    if (cmd_i.commit) begin
      if (item_clear_q) begin
        out_q <= '0;
      end else begin
        out_q.hit           <= hit_q;
        out_q.frame_index   <= slot_ext[FRAME_FIELD_W-1:0];
        out_q.evicted_valid <= evict_q;
        out_q.evicted_page  <= evict_q ? ev_ext[PAGE_FIELD_W-1:0] : '0;
        out_q.fault_total   <= fault_next;
        if (!hit_q) page_q[slot_q] <= item_page_q;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== rtl/core/lrupf_checker.sv =====
module lrupf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input lrupf_pkg::in_item_t         in_item_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input lrupf_pkg::out_item_t        out_item_o
);
  import lrupf_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  // Stalled input item holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed under stall");

  // One item in search at a time.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted during search");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.hit |-> !out_item_o.evicted_valid)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.evicted_valid |-> out_item_o.evicted_page == '0)
    else $error("evicted page set without eviction");

endmodule

bind lru_page_frame_replacement lrupf_checker u_lrupf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== dv/lru_page_frame_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, result and config channels of the LRU page frame store,
// keeps its own copy of the frame table and checks every result in order.
module lru_page_frame_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  lrupf_pkg::in_item_t         in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  lrupf_pkg::out_item_t        out_item_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [lrupf_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o,
  output int unsigned                 checked_o,
  output int unsigned                 hit_count_o
);
  import lrupf_pkg::*;

  localparam int unsigned NUM_FRAMES = 16;

  logic [PAGE_FIELD_W-1:0]  resident_page  [NUM_FRAMES];
  logic                     resident_valid [NUM_FRAMES];
  logic [FRAME_FIELD_W-1:0] age_rank       [NUM_FRAMES];
  logic [FAULT_W-1:0]       fault_count;
  logic [CFG_W-1:0]         frames_cfg;

  out_item_t   expected_results[$];
  int unsigned fails;
  int unsigned checked;
  int unsigned hits;

  function automatic int unsigned active_frames();
    int unsigned n;
    n = 32'(frames_cfg);
    if (n < 1) n = 1;
    if (n > NUM_FRAMES) n = NUM_FRAMES;
    return n;
  endfunction

  // Age every valid active frame younger than limit, except skip; ranks saturate.
  function automatic void age_others(int unsigned n, int unsigned limit, int unsigned skip);
    for (int unsigned i = 0; i < n; i++) begin
      if (i != skip && resident_valid[i] && age_rank[i] < limit &&
          age_rank[i] < NUM_FRAMES - 1) begin
        age_rank[i] = age_rank[i] + 1'b1;
      end
    end
  endfunction

  function automatic out_item_t predict_access(in_item_t item);
    out_item_t   res;
    int unsigned n;
    int unsigned slot;
    int unsigned oldest;
    bit          found;
    res = '0;
    n = active_frames();
    if (item.command == CMD_CLEAR) begin
      for (int unsigned i = 0; i < NUM_FRAMES; i++) begin
        resident_valid[i] = 1'b0;
        age_rank[i]       = '0;
      end
      fault_count = '0;
      return res;
    end
    found = 1'b0;
    slot  = 0;
    // lowest matching frame wins when a page sits in two frames
    for (int unsigned i = 0; i < n && !found; i++) begin
      if (resident_valid[i] && resident_page[i] == item.page_number) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      age_others(n, 32'(age_rank[slot]), slot);
      age_rank[slot] = '0;
    end else begin
      if (fault_count != FAULT_MAX) fault_count = fault_count + 1'b1;
      for (int unsigned i = 0; i < n && !found; i++) begin
        if (!resident_valid[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        // oldest frame goes, lowest index on a tie
        oldest = 0;
        slot   = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (age_rank[i] > oldest) begin
            oldest = 32'(age_rank[i]);
            slot   = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = resident_page[slot];
      end
      age_others(n, 32'hFFFF_FFFF, slot);
      resident_page[slot]  = item.page_number;
      resident_valid[slot] = 1'b1;
      age_rank[slot]       = '0;
    end
    res.frame_index = slot[FRAME_FIELD_W-1:0];
    res.fault_total = fault_count;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NUM_FRAMES; i++) begin
        resident_page[i]  = '0;
        resident_valid[i] = 1'b0;
        age_rank[i]       = '0;
      end
      fault_count = '0;
      frames_cfg  = FRAMES_IN_USE_RESET;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) frames_cfg = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation waiting");
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_item_i.hit));
          check_field("frame_index", 32'(want.frame_index), 32'(out_item_i.frame_index));
          check_field("evicted_valid", 32'(want.evicted_valid),
                      32'(out_item_i.evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page),
                      32'(out_item_i.evicted_page));
          check_field("fault_total", 32'(want.fault_total), 32'(out_item_i.fault_total));
          checked++;
          if (want.hit) hits++;
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_access(in_item_i));
    end
    pending_o    <= expected_results.size();
    fail_count_o <= fails;
    checked_o    <= checked;
    hit_count_o  <= hits;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the LRU page frame store. The checker instance
// beside the block does all prediction and comparison.
module testbench;
  import lrupf_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int unsigned PHASE_ITEMS     = 103;
  localparam int unsigned NUM_PHASES      = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_item_t        out_item_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned checked;
  int unsigned hit_count;
  int unsigned items_sent;
  int unsigned clears_sent;
  int unsigned cfg_writes;
  int unsigned idle_cycles = 0;

  // Knobs shared between the sender and the receiver process.
  bit tx_idle_en;
  bit rx_idle_en;
  bit hold_off_req;

  always #4 clk_i = ~clk_i;

  lru_page_frame_replacement DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  lru_page_frame_checker check_lru (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count),
    .checked_o    (checked),
    .hit_count_o  (hit_count)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until the block takes it. Called on a clock edge;
  // returns on the edge of acceptance or after the idle gap that follows.
  task automatic send_item(input logic cmd, input logic [PAGE_FIELD_W-1:0] page);
    in_item_t    item;
    int unsigned gap;
    item.command     = cmd;
    item.page_number = page;
    in_item_i  <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every expected result is back, let the pipeline settle,
  // then write frames_in_use.
  task automatic set_frames(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  // Random references around a small page window so hits and evictions are
  // frequent, with some full-range pages and the odd clear mixed in.
  task automatic run_random_phase(input int unsigned count, input int unsigned pool);
    logic [PAGE_FIELD_W-1:0] base;
    logic [PAGE_FIELD_W-1:0] page;
    int unsigned             r;
    base = PAGE_FIELD_W'($urandom);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        send_item(CMD_CLEAR, PAGE_FIELD_W'($urandom));
      end else if (r < 10) begin
        send_item(CMD_REFERENCE, PAGE_FIELD_W'($urandom));
      end else begin
        page = base + PAGE_FIELD_W'($urandom_range(0, pool - 1));
        send_item(CMD_REFERENCE, page);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request so the block
  // backs up into its input while the sender keeps offering items.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (rx_idle_en && stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (rx_idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] setting;
    int unsigned      active;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_off_req = 1'b0;
    items_sent   = 0;
    clears_sent  = 0;
    cfg_writes   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: four frames, fill with extreme pages, hit, then two evictions.
    set_frames(5'd4);
    send_item(CMD_REFERENCE, 16'h0000);
    send_item(CMD_REFERENCE, 16'hFFFF);
    send_item(CMD_REFERENCE, 16'h1234);
    send_item(CMD_REFERENCE, 16'hEDCB);
    send_item(CMD_REFERENCE, 16'h0000);
    send_item(CMD_REFERENCE, 16'h5555);
    send_item(CMD_REFERENCE, 16'hAAAA);
    // clear ignores its page; fault count restarts
    send_item(CMD_CLEAR, 16'hFFFF);
    send_item(CMD_REFERENCE, 16'hAAAA);
    send_item(CMD_REFERENCE, 16'hAAAA);
    send_item(CMD_REFERENCE, 16'h00FF);
    send_item(CMD_REFERENCE, 16'hFF00);
    // shrink to two: FF00 sits in frame 2, now outside, so it misses and
    // lands again in the low frames
    set_frames(5'd2);
    send_item(CMD_REFERENCE, 16'hFF00);
    // oversized count acts as all frames: the duplicate hits the lowest copy
    set_frames(5'd31);
    send_item(CMD_REFERENCE, 16'hFF00);
    send_item(CMD_REFERENCE, 16'h00FF);
    send_item(CMD_REFERENCE, 16'h3C3C);
    // zero acts as a single frame
    set_frames(5'd0);
    send_item(CMD_REFERENCE, 16'h0F0F);
    send_item(CMD_REFERENCE, 16'h0F0F);
    send_item(CMD_REFERENCE, 16'hF0F0);
    // back to all frames: stale ranks above the old count now take part
    set_frames(5'd16);
    send_item(CMD_REFERENCE, 16'h3C3C);
    send_item(CMD_REFERENCE, 16'h8001);

    // Random phases, each under its own frame count.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: setting = 5'd16;
        1: setting = 5'd3;
        2: setting = 5'd1;
        3: setting = 5'd8;
        4: setting = 5'd17;
        5: setting = 5'd2;
        6: setting = 5'd12;
        7: setting = 5'd0;
        8: setting = 5'd31;
        default: setting = CFG_W'($urandom_range(0, 31));
      endcase
      set_frames(setting);
      active = (setting == 0) ? 1 : (setting > 16) ? 16 : 32'(setting);
      // one stretch with no idling on either side
      tx_idle_en = (p != 5);
      rx_idle_en = (p != 5);
      // receiver backs off for a long while at the start of this phase
      if (p == 3) hold_off_req = 1'b1;
      run_random_phase(PHASE_ITEMS, active + $urandom_range(1, active + 2));
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d items (%0d clears), %0d results checked with %0d hits,",
             items_sent, clears_sent, checked, hit_count);
    $display("over %0d frame-count writes incl. 0 and 31, and one long receiver hold-off.",
             cfg_writes);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== lru_page_frame_replacement.f =====
rtl/core/lrupf_pkg.sv
rtl/core/lrupf_ctrl.sv
rtl/core/lrupf_victim.sv
rtl/core/lrupf_datapath.sv
rtl/core/lru_page_frame_replacement.sv
rtl/core/lrupf_checker.sv
dv/lru_page_frame_checker.sv
dv/testbench.sv
